// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the base64 encoder RTL.
// Expects clk and rst_n to be in scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/b64e_pkg.sv =====
// Package for the base64 encoder: group type, character codes, alphabet.
// No dependencies.
package b64e_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] CHAR_PAD   = 7'h3D; // '='
    localparam logic [6:0] CHAR_PLUS  = 7'h2B; // '+'
    localparam logic [6:0] CHAR_SLASH = 7'h2F; // '/'
    localparam logic [6:0] CHAR_UPPER = 7'h41; // 'A'
    localparam logic [6:0] CHAR_LOWER = 7'h61; // 'a'
    localparam logic [6:0] CHAR_DIGIT = 7'h30; // '0'

    localparam logic [1:0] IDX_LAST = 2'd3;

    // One complete (or final, short) group of up to three bytes.
    typedef struct packed {
        logic [23:0] bits;     // first byte in 23..16, zero filled
        logic [1:0]  n_bytes;  // 1..3
        logic        last;     // group ends the message
    } group_t;

    // Queue status seen by the front and back.
    typedef struct packed {
        logic full;
        logic head_valid;
    } queue_status_t;

    function automatic logic [6:0] enc_char(input logic [5:0] v);
        logic [6:0] ext;
        logic [6:0] c;
        ext = {1'b0, v};
        case (v) inside
            [6'd0:6'd25]:  c = CHAR_UPPER + ext;
            [6'd26:6'd51]: c = CHAR_LOWER + ext - 7'd26;
            [6'd52:6'd61]: c = CHAR_DIGIT + ext - 7'd52;
            6'd62:         c = CHAR_PLUS;
            default:       c = CHAR_SLASH;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/b64e_byte_if.sv =====
// Byte channel: one message byte per transaction, with end-of-message flag.
// No dependencies.
interface b64e_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/b64e_char_if.sv =====
// Character channel: one ASCII base64 character per transaction.
// No dependencies.
interface b64e_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       message_end;

    modport source (output valid, output out_char, output message_end, input ready);
    modport sink   (input valid, input out_char, input message_end, output ready);
endinterface

// ===== rtl/core/b64e_front.sv =====
// Front end: gathers input bytes into groups of three, pushes groups to the queue.
// Depends on b64e_pkg, b64e_byte_if, assert_macros.svh.
`include "assert_macros.svh"

module b64e_front
    import b64e_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    b64e_byte_if.sink     bytes,
    input  queue_status_t q_status,
    output logic          push,
    output group_t        push_group
);

    logic [15:0] pend_reg, pend_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        accept;
    logic        held_two;

    assign bytes.ready = !q_status.full;
    assign accept      = bytes.valid && bytes.ready;
    assign held_two    = (cnt_reg >= 2'd2);

    always_comb
    begin
        pend_next  = pend_reg;
        cnt_next   = cnt_reg;
        push       = 1'b0;
        push_group = '0;
        push_group.last = bytes.last_byte;
        case (cnt_reg)
            2'd0:
            begin
                push_group.bits    = {bytes.data_byte, 16'h0000};
                push_group.n_bytes = 2'd1;
            end
            2'd1:
            begin
                push_group.bits    = {pend_reg[15:8], bytes.data_byte, 8'h00};
                push_group.n_bytes = 2'd2;
            end
            default:
            begin
                push_group.bits    = {pend_reg, bytes.data_byte};
                push_group.n_bytes = 2'd3;
            end
        endcase
        if (accept)
        begin
            if (!held_two && !bytes.last_byte)
            begin
                if (cnt_reg == 2'd0)
                    pend_next = {bytes.data_byte, 8'h00};
                else
                    pend_next = {pend_reg[15:8], bytes.data_byte};
                cnt_next = cnt_reg + 2'd1;
            end
            else
            begin
                push      = 1'b1;
                pend_next = '0;
                cnt_next  = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
        end
    end

    `ASSERT_ALWAYS(a_cnt_max, cnt_reg != 2'd3, "front: held byte count reached three")
    `ASSERT_IMPLY(a_push_room, push, !q_status.full, "front: push into a full queue")

endmodule

// ===== rtl/core/b64e_queue.sv =====
// Short group queue between the front and back ends.
// Depends on b64e_pkg, assert_macros.svh.
`include "assert_macros.svh"

module b64e_queue
    import b64e_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  group_t        push_group,
    input  logic          pop,
    output group_t        head,
    output queue_status_t status
);

    group_t                entries [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CW-1:0]   count_reg;

    assign status.full       = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign status.head_valid = (count_reg != '0);
    assign head              = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_group;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    `ASSERT_ALWAYS(a_count_max, count_reg <= QUEUE_CW'(QUEUE_DEPTH), "queue: count overflow")
    `ASSERT_IMPLY(a_pop_nonempty, pop, count_reg != '0, "queue: pop from empty queue")

endmodule

// ===== rtl/core/b64e_back.sv =====
// Back end: each queued group gives four characters, one per cycle unless stalled,
// via an output register. Depends on b64e_pkg, b64e_char_if, assert_macros.svh.
`include "assert_macros.svh"

module b64e_back
    import b64e_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  group_t        head,
    input  queue_status_t q_status,
    output logic          pop,
    b64e_char_if.source   chars
);

    logic [1:0] idx_reg;
    logic       out_valid_reg;
    logic [6:0] out_char_reg;
    logic       out_end_reg;
    logic       load;
    logic [5:0] sextet;
    logic       pad;
    logic [6:0] char_next;

    assign load = q_status.head_valid && (!out_valid_reg || chars.ready);
    assign pop  = load && (idx_reg == IDX_LAST);

    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = head.bits[23:18];
            2'd1:    sextet = head.bits[17:12];
            2'd2:    sextet = head.bits[11:6];
            default: sextet = head.bits[5:0];
        endcase
        case (idx_reg)
            2'd2:    pad = (head.n_bytes < 2'd2);
            2'd3:    pad = (head.n_bytes < 2'd3);
            default: pad = 1'b0;
        endcase
        char_next = pad ? CHAR_PAD : enc_char(sextet);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg <= char_next;
            out_end_reg  <= head.last && (idx_reg == IDX_LAST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg       <= idx_reg + 2'd1;
                out_valid_reg <= 1'b1;
            end
            else if (chars.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign chars.valid       = out_valid_reg;
    assign chars.out_char    = out_char_reg;
    assign chars.message_end = out_end_reg;

    `ASSERT_IMPLY(a_mid_group, idx_reg != 2'd0, q_status.head_valid, "back: group left mid-way")
    `ASSERT_IMPLY(a_end_wrap, out_valid_reg && out_end_reg, idx_reg == 2'd0,
                  "back: message end shown before group wrapped")

endmodule

// ===== rtl/core/base64_encoder.sv =====
// Top level of the streaming base64 encoder (standard alphabet, '=' padding).
// Depends on b64e_pkg, b64e_byte_if, b64e_char_if, b64e_front, b64e_queue, b64e_back.
//
// Usage:
//   bytes : input channel, one message byte per transaction (data_byte), with
//           last_byte high on the final byte of the message.
//   chars : output channel, one 7-bit ASCII character per transaction
//           (out_char); message_end is high on the final character of a message.
//   Every group of three bytes, and the short group closed by last_byte, gives
//   four characters; a short group is zero filled and padded with '='.
//   Path: with the back end idle, a group closed by an accepted byte is
//   written to the queue, and its first character is then loaded into the
//   output register, from which it shows on chars.
//   Throughput: the back end sends one character per cycle while the receiver
//   takes them. Bytes that do not close a group are taken every cycle while
//   the queue has room.
//   The two-entry group queue lets the front keep gathering while the back
//   end waits on a stalled receiver; when it fills, bytes.ready drops.
//   Output stalls hold the character register unchanged until taken.
//   Reset (rst_n, asynchronous, active low) clears held bytes, the queue and
//   the output valid; the next byte starts a new message.
module base64_encoder
    import b64e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    b64e_byte_if.sink   bytes,
    b64e_char_if.source chars
);

    logic          push;
    group_t        push_group;
    logic          pop;
    group_t        head;
    queue_status_t q_status;

    // Front: byte gathering, one group pushed per closing byte
    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .q_status   (q_status),
        .push       (push),
        .push_group (push_group)
    );

    // Decoupling queue
    b64e_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // Back: character serialiser with output register
    b64e_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .chars    (chars)
    );

endmodule
